[hdl/agpf_pkg.sv]
// ----------------------------------------------------------------------------
// agpf_pkg - shared types and constants for the pose fusion block
// Gain type, widths and config register indices used by the divider and the top level.
// ----------------------------------------------------------------------------
package agpf_pkg;
    localparam int GAIN_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 22;

    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_ONE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_TWO = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_OFFSET   = 2'd2;

    typedef logic [GAIN_BITS-1:0] t_gain;
endpackage

[hdl/agpf_div.sv]
// ----------------------------------------------------------------------------
// agpf_div - fractional restoring divider
// q = floor(n * 2^16 / d), one quotient bit per cycle; 65535 if n >= d, 0 if d == 0.
// ----------------------------------------------------------------------------
module agpf_div #(
    parameter int W = 72
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [W-1:0]          i_num,
    input  logic [W-1:0]          i_den,
    output logic                  o_done,
    output agpf_pkg::t_gain       o_quot
);
    import agpf_pkg::*;

    logic [W:0]   r_rem, n_rem;
    logic [W-1:0] r_den;
    t_gain        r_q, n_q;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy, r_done, n_done;
    logic [W:0]   w_sh;

    assign w_sh = {r_rem[W-1:0], 1'b0};

    always_comb begin
        n_rem = r_rem; n_q = r_q; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_rem = {1'b0, i_num};
            if (i_den == '0) begin
                n_q = '0; n_done = 1'b1;
            end else if (i_num >= i_den) begin
                n_q = '1; n_done = 1'b1;
            end else begin
                n_q = '0; n_cnt = 5'(GAIN_BITS); n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q = {r_q[GAIN_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q = {r_q[GAIN_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_q <= n_q;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[hdl/adaptive_gain_pose_fusion.sv]
// ----------------------------------------------------------------------------
// adaptive_gain_pose_fusion - two-source adaptive gain x,y fusion
// ----------------------------------------------------------------------------
// Slave stream: one word carries src1_x, src1_y, src2_x, src2_y.
// Master stream: one word carries fused_x, fused_y, the estimate after the word.
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data; index 0 weight one, 1 weight
// two, 2 source one y offset. Write only while idle.
// Each word runs four sub-steps in order (src1 x, src1 y, src2 x, src2 y). A
// sub-step forms fp, then num/den, then runs a divide for the new gain, a
// second divide, a step multiply and a writeback; the bit-serial divider sets
// its pace (two divides per sub-step). A divide whose den is zero or whose num
// reaches den skips the bit-serial loop. A new word is taken only once the
// last result has moved to the output register.
// s_axis_tready is high only while idle. A stalled receiver holds the result in
// the output register while the next word is computed; that word then waits
// until the output register is free, and no further word is taken meanwhile.
// Reset clears estimates, gains and previous measurements to zero and loads
// the register reset values.
// ----------------------------------------------------------------------------
module adaptive_gain_pose_fusion #(
    parameter int POS_WIDTH = 22,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // src1_x, src1_y, src2_x, src2_y from bit 0 up
    input  logic [((4*POS_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fused_x, fused_y from bit 0 up
    output logic [((2*POS_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [agpf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [POS_WIDTH-1:0]                i_cfg_data
);
    import agpf_pkg::*;

    localparam int P = POS_WIDTH;
    localparam int OW = ((2*P+7)/8)*8;
    localparam int DW = WEIGHT_BITS + GAIN_BITS + 1 + FRAC_BITS + 2;
    localparam int MW = P + 1 + GAIN_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_WB   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam logic signed [P:0] PMAX = (P+1)'((64'd1 << (P-1)) - 64'd1);
    localparam logic signed [P:0] PMIN = -PMAX - (P+1)'(1);

    logic [WEIGHT_BITS-1:0] r_w1, r_w2;
    logic signed [P-1:0]    r_yoff;
    logic signed [P-1:0]    r_est [2];
    logic signed [P-1:0]    r_prev [4];
    t_gain                  r_gain [4];
    logic signed [P-1:0]    r_meas [4];
    logic [2:0]             r_st;
    logic [1:0]             r_slot;
    logic [P:0]             r_fp;
    logic [DW-1:0]          r_num, r_den;
    logic [MW-1:0]          r_prod;
    logic                   r_ovalid;
    logic [2*P-1:0]         r_odata;
    logic                   r_dstart;
    logic                   w_ddone;
    t_gain                  w_q;

    logic [WEIGHT_BITS-1:0] w_a;
    logic signed [P-1:0]    w_e, w_m;
    logic signed [P:0]      w_diff, w_delta, w_ysum, w_new;
    logic [P:0]             w_mag;
    logic [P:0]             w_step;
    logic signed [P:0]      w_sum;
    t_gain                  w_kg;
    logic [WEIGHT_BITS+GAIN_BITS-1:0] w_akg;
    logic [DW-1:0]          w_fps, w_n, w_d;
    logic                   w_oload;

    assign w_a = r_slot[1] ? r_w2 : r_w1;
    assign w_e = r_est[r_slot[0]];
    assign w_m = r_meas[r_slot];
    assign w_diff = {w_e[P-1], w_e} - {r_prev[r_slot][P-1], r_prev[r_slot]};
    assign w_delta = {w_m[P-1], w_m} - {w_e[P-1], w_e};
    assign w_mag = w_delta[P] ? (P+1)'(-w_delta) : w_delta;
    assign w_kg = (r_st == ST_MUL2) ? w_q : r_gain[r_slot];
    assign w_akg = w_a * w_kg;
    assign w_fps = DW'(r_fp) << GAIN_BITS;
    assign w_n = (DW'(w_akg) << FRAC_BITS) + w_fps;
    assign w_d = ((DW'(w_akg) + (DW'(w_a) << GAIN_BITS)) << FRAC_BITS) + w_fps;
    assign w_step = r_prod[MW-1:GAIN_BITS];
    assign w_sum = w_delta[P] ? {w_e[P-1], w_e} - $signed(w_step)
                              : {w_e[P-1], w_e} + $signed(w_step);
    assign w_new = w_sum;
    assign w_ysum = {s_axis_tdata[2*P-1], s_axis_tdata[2*P-1:P]} + {r_yoff[P-1], r_yoff};
    // result moves to the output register once that register is free
    assign w_oload = (r_st == ST_OUT) && (!r_ovalid || m_axis_tready);

    agpf_div #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_q)
    );

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = OW'(r_odata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= 16'd16384; r_w2 <= 16'd128;
            r_yoff <= P'(-19661);
            r_est[0] <= '0; r_est[1] <= '0;
            for (int i = 0; i < 4; i++) begin
                r_prev[i] <= '0; r_gain[i] <= '0;
            end
            r_st <= ST_IDLE; r_slot <= '0; r_ovalid <= 1'b0; r_dstart <= 1'b0;
        end else begin
            r_dstart <= (r_st == ST_DIV1) || ((r_st == ST_MUL2) && w_ddone);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WEIGHT_ONE: r_w1 <= i_cfg_data[WEIGHT_BITS-1:0];
                    REG_WEIGHT_TWO: r_w2 <= i_cfg_data[WEIGHT_BITS-1:0];
                    REG_Y_OFFSET:   r_yoff <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_oload) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_meas[0] <= s_axis_tdata[P-1:0];
                        r_meas[1] <= (w_ysum > PMAX) ? PMAX[P-1:0] :
                                     (w_ysum < PMIN) ? PMIN[P-1:0] : w_ysum[P-1:0];
                        r_meas[2] <= s_axis_tdata[3*P-1:2*P];
                        r_meas[3] <= s_axis_tdata[4*P-1:3*P];
                        r_slot <= '0;
                        r_st <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    r_fp <= w_diff[P] ? (P+1)'(-w_diff) : w_diff;
                    r_prev[r_slot] <= w_m;
                    r_st <= ST_DIV1;
                end
                ST_DIV1: begin
                    // fp is registered; form num/den and start the gain divide
                    r_num <= w_n; r_den <= w_d;
                    r_st <= ST_MUL2;
                end
                ST_MUL2: begin
                    if (w_ddone) begin
                        r_gain[r_slot] <= w_q;
                        r_num <= w_n; r_den <= w_d;
                        r_st <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (w_ddone) begin
                        r_prod <= MW'(w_mag) * MW'(w_q);
                        r_st <= ST_STEP;
                    end
                end
                ST_STEP: r_st <= ST_WB;
                ST_WB: begin
                    r_est[r_slot[0]] <= (w_new > PMAX) ? PMAX[P-1:0] :
                                        (w_new < PMIN) ? PMIN[P-1:0] : w_new[P-1:0];
                    r_slot <= r_slot + 2'd1;
                    r_st <= (r_slot == 2'd3) ? ST_OUT : ST_MUL1;
                end
                ST_OUT: begin
                    if (w_oload) begin
                        r_odata <= {r_est[1], r_est[0]};
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - adaptive gain pose fusion block
// Drives position words over the input stream, predicts the fused x,y estimate
// with a bit-accurate model of the gain update, and checks every output word.
// ----------------------------------------------------------------------------
module testbench;
    import agpf_pkg::*;

    localparam int PW = 22;
    localparam int IW = ((4*PW+7)/8)*8;
    localparam int OW = ((2*PW+7)/8)*8;
    localparam longint PMAX = (64'sd1 <<< (PW-1)) - 1;
    localparam longint PMIN = -PMAX - 1;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    adaptive_gain_pose_fusion DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    longint unsigned wt_one, wt_two;
    longint y_off;
    longint est [2];
    longint prev_meas [4];
    longint unsigned kgain [4];

    logic [PW-1:0] fused_x_q [$];
    logic [PW-1:0] fused_y_q [$];
    int errors = 0;
    longint cycles = 0;
    bit rx_hold = 0;     // long receiver hold-off
    bit rx_calm = 0;     // no random receiver stalls
    bit tx_calm = 0;

    function automatic longint sat_pos(longint v);
        if (v > PMAX) return PMAX;
        if (v < PMIN) return PMIN;
        return v;
    endfunction

    function automatic longint unsigned gain_div(longint unsigned n, longint unsigned d);
        longint unsigned rem, q;
        if (d == 0) return 0;
        if (n >= d) return 65535;
        rem = n;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
                rem -= d;
                q |= 1;
            end
        end
        return q;
    endfunction

    task automatic fuse_axis(int slot, int axis, longint unsigned a, longint m);
        longint e, diff, delta;
        longint unsigned fp, num, den, r, mag, stp, kg;
        e = est[axis];
        diff = e - prev_meas[slot];
        fp = (diff < 0) ? -diff : diff;
        prev_meas[slot] = m;
        kg = kgain[slot];
        num = ((a * kg) << 16) + (fp << 16);
        den = ((a * (65536 + kg)) << 16) + (fp << 16);
        kg = gain_div(num, den);
        kgain[slot] = kg;
        num = ((a * kg) << 16) + (fp << 16);
        den = ((a * (65536 + kg)) << 16) + (fp << 16);
        r = gain_div(num, den);
        delta = m - e;
        mag = (delta < 0) ? -delta : delta;
        stp = (mag * r) >> 16;
        e = (delta < 0) ? e - longint'(stp) : e + longint'(stp);
        est[axis] = sat_pos(e);
    endtask

    task automatic predict_fusion(logic signed [PW-1:0] ax, ay, bx, by);
        fuse_axis(0, 0, wt_one, ax);
        fuse_axis(1, 1, wt_one, sat_pos(longint'(ay) + y_off));
        fuse_axis(2, 0, wt_two, bx);
        fuse_axis(3, 1, wt_two, by);
        fused_x_q.push_back(est[0][PW-1:0]);
        fused_y_q.push_back(est[1][PW-1:0]);
    endtask

    task automatic send_word(longint ax, ay, bx, by);
        do @(negedge i_clk); while (!tx_calm && $urandom_range(99) < 26);
        s_axis_tdata <= IW'({by[PW-1:0], bx[PW-1:0], ay[PW-1:0], ax[PW-1:0]});
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_fusion(ax[PW-1:0], ay[PW-1:0], bx[PW-1:0], by[PW-1:0]);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (fused_x_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint v);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[CFG_DATA_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WEIGHT_ONE) wt_one = v[15:0];
        else if (idx == REG_WEIGHT_TWO) wt_two = v[15:0];
        else if (idx == REG_Y_OFFSET) y_off = longint'($signed(v[PW-1:0]));
    endtask

    function automatic longint rand_pos();
        case ($urandom_range(9))
            0: return PMAX;
            1: return PMIN;
            2: return longint'($urandom_range(2000)) - 1000;
            default: return longint'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_word(0, 0, 0, 0);
        send_word(65536, 65536, 65536, 65536);
        send_word(PMAX, PMAX, PMAX, PMAX);
        send_word(PMIN, PMIN, PMIN, PMIN);
        send_word(PMIN, PMAX, PMAX, PMIN);
        wait_drain();
    endtask

    task automatic test_offset_saturation();
        write_reg(REG_Y_OFFSET, PMAX);
        send_word(0, PMAX, 0, 0);
        send_word(0, 100, 0, 0);
        write_reg(REG_Y_OFFSET, PMIN);
        send_word(0, PMIN, 0, 0);
        send_word(0, -100, 0, 0);
        wait_drain();
    endtask

    task automatic test_weight_extremes();
        write_reg(REG_WEIGHT_ONE, 1);
        write_reg(REG_WEIGHT_TWO, 65535);
        write_reg(REG_Y_OFFSET, 0);
        send_word(1000, -1000, 5000, 7);
        send_word(PMAX, PMIN, 0, 1);
        write_reg(REG_WEIGHT_ONE, 65535);
        write_reg(REG_WEIGHT_TWO, 1);
        send_word(PMIN, PMAX, 12345, -12345);
        send_word(3, 3, 3, 3);
        // zero weight: gain saturates when fp is nonzero, zero when fp is zero
        write_reg(REG_WEIGHT_ONE, 0);
        write_reg(REG_WEIGHT_TWO, 0);
        send_word(4000, 4000, 4000, 4000);
        send_word(4000, 4000, 4000, 4000);
        send_word(-9, 77, 0, 0);
        // unused index must be ignored
        write_reg(REG_NONE, 22'h155555);
        send_word(-500, 600, 700, -800);
        wait_drain();
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_word(rand_pos(), rand_pos(), rand_pos(), rand_pos());
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_WEIGHT_ONE, (p == 0) ? 65535 : $urandom_range(65535, 1));
            write_reg(REG_WEIGHT_TWO, (p == 1) ? 1 : $urandom_range(65535, 1));
            write_reg(REG_Y_OFFSET, $urandom);
            if (p == 2) begin
                tx_calm = 1;
                rx_calm = 1;
            end
            random_phase(315);
            tx_calm = 0;
            rx_calm = 0;
            wait_drain();
        end
    endtask

    // receiver holds off while words keep coming; sender then pauses to drain
    task automatic test_backpressure();
        rx_hold = 1;
        fork
            random_phase(8);
            begin
                repeat (3000) @(negedge i_clk);
                rx_hold = 0;
            end
        join
        wait_drain();
        random_phase(30);
        wait_drain();
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && !rx_hold && (rx_calm || $urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fused_x_q.size() == 0) begin
                $error("unexpected output word %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata[PW-1:0] !== fused_x_q[0]) begin
                    $error("fused_x expected %h actual %h", fused_x_q[0], m_axis_tdata[PW-1:0]);
                    errors++;
                end
                if (m_axis_tdata[2*PW-1:PW] !== fused_y_q[0]) begin
                    $error("fused_y expected %h actual %h", fused_y_q[0],
                           m_axis_tdata[2*PW-1:PW]);
                    errors++;
                end
                void'(fused_x_q.pop_front());
                void'(fused_y_q.pop_front());
            end
        end
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wt_one = 16384;
        wt_two = 128;
        y_off = -19661;
        est = '{0, 0};
        prev_meas = '{0, 0, 0, 0};
        kgain = '{0, 0, 0, 0};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_offset_saturation();
        test_weight_extremes();
        test_backpressure();
        test_random();
        wait_drain();
        if (errors == 0 && fused_x_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
